// ----- rtl/edd_pkg.sv -----
// Shared types and constants for the error-diffusion dither block.
// No dependencies; used by the channel interfaces and every module.
package edd_pkg;

  localparam int unsigned PIX_W         = 16;
  localparam int unsigned LVL_W         = 16;
  localparam int unsigned IW_W          = 13;
  localparam int unsigned ANC_W         = 3;
  localparam int unsigned DVS_W         = 8;
  localparam int unsigned COEF_W        = 8;
  localparam int unsigned KROW_W        = 40;
  localparam int unsigned ENT_W         = 32;
  localparam int unsigned STORE_ROWS    = 3;
  localparam int unsigned KERNEL_ROWS   = 3;
  localparam int unsigned KERNEL_COLS   = 5;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 40;
  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_ZERO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_ONE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KROW_TWO    = 3'd7;

  // Reset values of the registers
  localparam logic [LVL_W-1:0]  RST_MAX_LEVEL   = 16'd255;
  localparam logic [LVL_W-1:0]  RST_MIN_LEVEL   = 16'd0;
  localparam logic [IW_W-1:0]   RST_IMAGE_WIDTH = 13'd640;
  localparam logic [ANC_W-1:0]  RST_ANCHOR      = 3'd2;
  localparam logic [DVS_W-1:0]  RST_DIVISOR     = 8'd16;
  localparam logic [KROW_W-1:0] RST_KROW_ZERO   = 40'd1792;
  localparam logic [KROW_W-1:0] RST_KROW_ONE    = 40'd83165184;
  localparam logic [KROW_W-1:0] RST_KROW_TWO    = 40'd0;

  typedef struct packed {
    logic [LVL_W-1:0]                    max_level;
    logic [LVL_W-1:0]                    min_level;
    logic [IW_W-1:0]                     image_width;
    logic [ANC_W-1:0]                    anchor_column;
    logic [DVS_W-1:0]                    divisor;
    logic [STORE_ROWS-1:0][KROW_W-1:0]   kernel;
  } edd_cfg_t;

  typedef enum logic [1:0] {
    ADDR_CLR = 2'd0,
    ADDR_CTR = 2'd1,
    ADDR_TAP = 2'd2
  } edd_addr_e;

  typedef struct packed {
    logic      pix_ld;
    logic      pos_clr;
    logic      clr_rst;
    logic      clr_step;
    edd_addr_e addr_sel;
    logic      zero_wr;
    logic      sum_ld;
    logic      err_ld;
    logic      div_init;
    logic      div_step;
    logic      tap_rst;
    logic      tap_ld;
    logic      frac_ld;
    logic      amt_ld;
    logic      tap_wr;
    logic      tap_next;
    logic      out_ld;
  } edd_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic tap_ok;
    logic tap_last;
    logic out_free;
  } edd_sts_t;

endpackage

// ----- rtl/edd_intf.sv -----
// Valid/ready channel interfaces: pixel input, result output, register writes.
// Depends on edd_pkg for payload widths.
interface edd_pix_if import edd_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             start_of_frame;
  modport source(output valid, pixel_value, start_of_frame, input ready);
  modport sink(input valid, pixel_value, start_of_frame, output ready);
endinterface

interface edd_res_if import edd_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] out_level;
  logic             is_bright;
  modport source(output valid, out_level, is_bright, input ready);
  modport sink(input valid, out_level, is_bright, output ready);
endinterface

interface edd_cfg_if import edd_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/edd_ctrl.sv -----
// Sequencer for the dither block: clear pass, decision, division, tap loop.
// Depends on edd_pkg; drives edd_dpath through edd_cmd_t / edd_sts_t.
module edd_ctrl import edd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pix_valid_i,
  input  logic     pix_sof_i,
  output logic     pix_ready_o,
  input  edd_sts_t sts_i,
  output edd_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_CRD   = 4'd2;
  localparam logic [3:0] S_CSUM  = 4'd3;
  localparam logic [3:0] S_CERR  = 4'd4;
  localparam logic [3:0] S_DINIT = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_TSEL  = 4'd7;
  localparam logic [3:0] S_TFRAC = 4'd8;
  localparam logic [3:0] S_TAMT  = 4'd9;
  localparam logic [3:0] S_TWR   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  assign pix_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.addr_sel = ADDR_CTR;
    unique case (state_q)
      S_IDLE: begin
        if (pix_valid_i) begin
          cmd_o.pix_ld = 1'b1;
          if (pix_sof_i) begin
            cmd_o.pos_clr = 1'b1;
            cmd_o.clr_rst = 1'b1;
            pend_d        = 1'b1;
            state_d       = S_CLEAR;
          end else begin
            state_d = S_CRD;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.addr_sel = ADDR_CLR;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          pend_d  = 1'b0;
          state_d = pend_q ? S_CRD : S_IDLE;
        end
      end
      S_CRD: state_d = S_CSUM;
      S_CSUM: begin
        cmd_o.zero_wr = 1'b1;
        cmd_o.sum_ld  = 1'b1;
        state_d       = S_CERR;
      end
      S_CERR: begin
        cmd_o.err_ld = 1'b1;
        state_d      = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.tap_rst  = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_TSEL;
      end
      S_TSEL: begin
        cmd_o.addr_sel = ADDR_TAP;
        cmd_o.tap_ld   = 1'b1;
        if (sts_i.tap_ok) begin
          state_d = S_TFRAC;
        end else begin
          cmd_o.tap_next = 1'b1;
          if (sts_i.tap_last) state_d = S_FIN;
        end
      end
      S_TFRAC: begin
        cmd_o.addr_sel = ADDR_TAP;
        cmd_o.frac_ld  = 1'b1;
        state_d        = S_TAMT;
      end
      S_TAMT: begin
        cmd_o.addr_sel = ADDR_TAP;
        cmd_o.amt_ld   = 1'b1;
        state_d        = S_TWR;
      end
      S_TWR: begin
        cmd_o.addr_sel = ADDR_TAP;
        cmd_o.tap_wr   = 1'b1;
        cmd_o.tap_next = 1'b1;
        state_d        = sts_i.tap_last ? S_FIN : S_TSEL;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/edd_dpath.sv -----
// Datapath: error line stores, position, decision, radix-16 divider, tap math
// and the result register. Depends on edd_pkg; commanded by edd_ctrl.
module edd_dpath import edd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  edd_cfg_t         cfg_i,
  input  logic [PIX_W-1:0] pix_i,
  input  edd_cmd_t         cmd_i,
  output edd_sts_t         sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [LVL_W-1:0] out_level_o,
  output logic             out_bright_o
);

  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned TC_W      = COL_W + 3;
  localparam int unsigned PFX_W     = PIX_W + FRAC_BITS + 1;
  localparam int unsigned SUM_W     = ((PFX_W > ENT_W) ? PFX_W : ENT_W) + 1;
  localparam int unsigned ERR_W     = SUM_W + 1;
  localparam int unsigned DIV_W     = ((ERR_W + 3) / 4) * 4;
  localparam int unsigned DIV_STEPS = DIV_W / 4;
  localparam int unsigned DC_W      = $clog2(DIV_STEPS);
  localparam int unsigned PROD_W    = DIV_W + COEF_W;
  localparam int unsigned MAG_W     = PROD_W + 1;
  localparam int unsigned AMT_W     = MAG_W + 1;
  localparam int unsigned TOT_W     = AMT_W + 1;
  localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'(32'sh7FFF_FFFF);
  localparam logic signed [TOT_W-1:0] SAT_LO = TOT_W'(-32'sh7FFF_FFFF - 32'sd1);

  // Configuration derived values
  logic [COL_W:0]     wid;
  logic [DVS_W-1:0]   div_e;
  always_comb begin
    if (cfg_i.image_width == '0) wid = (COL_W+1)'(1);
    else if (32'(cfg_i.image_width) > MAX_WIDTH) wid = (COL_W+1)'(MAX_WIDTH);
    else wid = (COL_W+1)'(cfg_i.image_width);
    div_e = (cfg_i.divisor == '0) ? DVS_W'(1) : cfg_i.divisor;
  end

  // Position and pixel
  logic [COL_W-1:0] col_q;
  logic [1:0]       slot_q;
  logic [PIX_W-1:0] pix_q;
  logic [COL_W:0]   col_nx;

  assign col_nx = (COL_W+1)'(col_q) + (COL_W+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      slot_q <= '0;
    end else if (cmd_i.pos_clr) begin
      col_q  <= '0;
      slot_q <= '0;
    end else if (cmd_i.out_ld) begin
      if (col_nx >= wid) begin
        col_q  <= '0;
        slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
      end else begin
        col_q <= col_nx[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_ld) pix_q <= pix_i;
  end

  // Tap counters and tap geometry
  logic [2:0]              k_q;
  logic [1:0]              r_q;
  logic signed [TC_W-1:0]  tcol;
  logic [COEF_W-1:0]       coef;
  logic [2:0]              tslot_w;
  logic [1:0]              tslot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      r_q <= '0;
    end else if (cmd_i.tap_rst) begin
      k_q <= '0;
      r_q <= '0;
    end else if (cmd_i.tap_next) begin
      if (k_q == 3'(KERNEL_COLS - 1)) begin
        k_q <= '0;
        r_q <= r_q + 2'd1;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_comb begin
    tcol    = TC_W'(col_q) - TC_W'(cfg_i.anchor_column) + TC_W'(k_q);
    coef    = cfg_i.kernel[r_q][{k_q, 3'b000} +: COEF_W];
    tslot_w = 3'(slot_q) + 3'(r_q);
    tslot   = (tslot_w >= 3'd3) ? 2'(tslot_w - 3'd3) : tslot_w[1:0];
    sts_o.tap_last = (k_q == 3'(KERNEL_COLS - 1)) && (r_q == 2'(KERNEL_ROWS - 1));
    sts_o.tap_ok   = (coef != '0) && !tcol[TC_W-1]
                   && (unsigned'(tcol) < TC_W'(wid))
                   && ((r_q != 2'd0) || (unsigned'(tcol) > TC_W'(col_q)));
  end

  // Clear counter
  logic [COL_W-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_rst) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + COL_W'(1);
  end
  assign sts_o.clr_last = (clr_q == COL_W'(MAX_WIDTH - 1));

  // Line stores: one per store row, shared address, registered read
  logic [COL_W-1:0]                addr;
  logic [1:0]                      rslot;
  logic [STORE_ROWS-1:0]           we;
  logic [ENT_W-1:0]                wdata;
  logic [STORE_ROWS-1:0][ENT_W-1:0] rd_q;
  logic signed [ENT_W-1:0]         rdata;
  logic signed [ENT_W-1:0]         sat_val;

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_CLR: begin addr = clr_q; rslot = slot_q; end
      ADDR_CTR: begin addr = col_q; rslot = slot_q; end
      ADDR_TAP: begin addr = tcol[COL_W-1:0]; rslot = tslot; end
      default:  begin addr = col_q; rslot = slot_q; end
    endcase
    we = '0;
    if (cmd_i.clr_step) we = '1;
    else if (cmd_i.zero_wr || cmd_i.tap_wr) we[rslot] = 1'b1;
    wdata = cmd_i.tap_wr ? sat_val : '0;
    rdata = rd_q[rslot];
  end

  for (genvar g = 0; g < STORE_ROWS; g++) begin : g_store
    logic [ENT_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (we[g]) mem[addr] <= wdata;
      rd_q[g] <= mem[addr];
    end
  end

  // Decision
  logic signed [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0]        thr;
  logic signed [ERR_W-1:0] err_q;
  logic                    bright_q;

  assign thr = SUM_W'(cfg_i.max_level) << (FRAC_BITS - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_ld) sum_q <= (SUM_W'(pix_q) << FRAC_BITS) + SUM_W'(rdata);
    if (cmd_i.err_ld) begin
      bright_q <= sum_q > $signed(thr);
      if (sum_q > $signed(thr))
        err_q <= ERR_W'(sum_q) - (ERR_W'(cfg_i.max_level) << FRAC_BITS);
      else
        err_q <= ERR_W'(sum_q) - (ERR_W'(cfg_i.min_level) << FRAC_BITS);
    end
  end

  // Divider: |err| / divisor, four quotient bits a cycle
  logic [DIV_W-1:0] dq_q;
  logic [DVS_W-1:0] rem_q;
  logic             neg_q;
  logic [DC_W-1:0]  dc_q;
  logic [DIV_W-1:0] dq_n;
  logic [DVS_W-1:0] rem_n;
  logic [DVS_W:0]   tr;

  always_comb begin
    dq_n  = dq_q;
    rem_n = rem_q;
    for (int i = 0; i < 4; i++) begin
      tr   = {rem_n, dq_n[DIV_W-1]};
      dq_n = {dq_n[DIV_W-2:0], 1'b0};
      if (tr >= {1'b0, div_e}) begin
        tr      = tr - {1'b0, div_e};
        dq_n[0] = 1'b1;
      end
      rem_n = tr[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= err_q[ERR_W-1];
      dq_q  <= err_q[ERR_W-1] ? DIV_W'(unsigned'(-err_q)) : DIV_W'(unsigned'(err_q));
      rem_q <= '0;
      dc_q  <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= dq_n;
      rem_q <= rem_n;
      dc_q  <= dc_q + DC_W'(1);
    end
  end
  assign sts_o.div_last = (dc_q == DC_W'(DIV_STEPS - 1));

  // Tap amount: q*c + floor(r*c/d), signed by the error
  logic [PROD_W-1:0]      prod_q;
  logic [15:0]            rc_q;
  logic [7:0]             frac_q;
  logic [7:0]             fq;
  logic [8:0]             fr;
  logic signed [AMT_W-1:0] amt_q;
  logic [MAG_W-1:0]       mag;
  logic signed [TOT_W-1:0] tot;

  always_comb begin
    fr = {1'b0, rc_q[15:8]};
    fq = '0;
    for (int i = 7; i >= 0; i--) begin
      fr = {fr[7:0], rc_q[i]};
      if (fr >= {1'b0, div_e}) begin
        fr    = fr - {1'b0, div_e};
        fq[i] = 1'b1;
      end
    end
    mag = MAG_W'(prod_q) + MAG_W'(frac_q);
    tot = TOT_W'(amt_q) + TOT_W'(rdata);
    if (tot > SAT_HI) sat_val = ENT_W'(SAT_HI);
    else if (tot < SAT_LO) sat_val = ENT_W'(SAT_LO);
    else sat_val = tot[ENT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_ld) begin
      prod_q <= PROD_W'(dq_q) * PROD_W'(coef);
      rc_q   <= 16'(rem_q) * 16'(coef);
    end
    if (cmd_i.frac_ld) frac_q <= fq;
    if (cmd_i.amt_ld) amt_q <= neg_q ? -AMT_W'(mag) : AMT_W'(mag);
  end

  // Result register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_ld) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_level_o  <= bright_q ? cfg_i.max_level : cfg_i.min_level;
      out_bright_o <= bright_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/error_diffusion_dither_core.sv -----
// Top level of the error-diffusion dither block: register file, sequencer
// and datapath. Depends on edd_pkg, edd_intf, edd_ctrl and edd_dpath.
//
// Usage:
//   pix_i  - grey pixels in raster order; start_of_frame on the first pixel of
//            a frame wipes the three error line stores and the position.
//   res_o  - one dithered level per pixel (max_level or min_level) plus is_bright.
//   cfg_i  - register writes (index 0..7), always ready; write only while idle.
// Flow: one pixel at a time. For each pixel the error entry is read, the decision
//   is made and the error goes through the radix-16 divider; then each of the 15
//   kernel taps is checked in turn, and a tap with a nonzero coefficient that
//   lands in the image (in row 0 only to the right of the pixel) does a
//   read-modify-write of a line store entry. A start_of_frame pixel first runs
//   the clearing pass, which runs across all three stores in parallel.
// Reset: registers take their documented defaults and the clearing pass runs
//   before the first pixel is taken.
// Stall: the result sits in an output register; the next pixel is taken while
//   it waits, and is held at its end until the register frees up.
module error_diffusion_dither_core import edd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  edd_pix_if.sink   pix_i,
  edd_res_if.source res_o,
  edd_cfg_if.sink   cfg_i
);

  edd_cfg_t cfg_q;
  edd_cmd_t cmd;
  edd_sts_t sts;

  // Register file: always accept writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_level     <= RST_MAX_LEVEL;
      cfg_q.min_level     <= RST_MIN_LEVEL;
      cfg_q.image_width   <= RST_IMAGE_WIDTH;
      cfg_q.anchor_column <= RST_ANCHOR;
      cfg_q.divisor       <= RST_DIVISOR;
      cfg_q.kernel[0]     <= RST_KROW_ZERO;
      cfg_q.kernel[1]     <= RST_KROW_ONE;
      cfg_q.kernel[2]     <= RST_KROW_TWO;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MAX_LEVEL:   cfg_q.max_level     <= cfg_i.data[LVL_W-1:0];
        REG_MIN_LEVEL:   cfg_q.min_level     <= cfg_i.data[LVL_W-1:0];
        REG_IMAGE_WIDTH: cfg_q.image_width   <= cfg_i.data[IW_W-1:0];
        REG_ANCHOR:      cfg_q.anchor_column <= cfg_i.data[ANC_W-1:0];
        REG_DIVISOR:     cfg_q.divisor       <= cfg_i.data[DVS_W-1:0];
        REG_KROW_ZERO:   cfg_q.kernel[0]     <= cfg_i.data[KROW_W-1:0];
        REG_KROW_ONE:    cfg_q.kernel[1]     <= cfg_i.data[KROW_W-1:0];
        REG_KROW_TWO:    cfg_q.kernel[2]     <= cfg_i.data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: owns the pixel handshake, steps the datapath
  edd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_sof_i   (pix_i.start_of_frame),
    .pix_ready_o (pix_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: stores, arithmetic and the result register
  edd_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix_i        (pix_i.pixel_value),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_level_o  (res_o.out_level),
    .out_bright_o (res_o.is_bright)
  );

endmodule
